@@ hdl/eblm_pkg.sv @@
// ----------------------------------------------------------------------------
// eblm_pkg: shared types and codes for the edge block list manager
// Operation and status codes, edge key and back-reference record layouts.
// ----------------------------------------------------------------------------
package eblm_pkg;

  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_INCR   = 3'd1,
    MODE_INVAL  = 3'd2,
    MODE_DELETE = 3'd3,
    MODE_SETREF = 3'd4
  } mode_t;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOALLOC = 2'd1;
  localparam logic [1:0] ST_BADGRP  = 2'd2;

  // edge key: dest, weight, valid
  typedef struct packed {
    logic [19:0] dest;
    logic [15:0] weight;
    logic        valid;
  } edge_key_t;

  // back-reference record
  typedef struct packed {
    logic [19:0] hvtx;
    logic [15:0] hblock;
    logic [7:0]  hoff;
    logic        gen;
  } edge_ref_t;

  localparam int KEY_W = $bits(edge_key_t);
  localparam int REF_W = $bits(edge_ref_t);

endpackage

@@ hdl/edge_block_list_manager.sv @@
// ----------------------------------------------------------------------------
// edge_block_list_manager: chained edge block lists per vertex group
// Sequencer over group, edge and link memories with a bump allocator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command: insert, weight
//   increment, invalidate, compacting delete or back-reference update.
//   Output channel (out_valid/out_ready) returns one result per command:
//   status, placed slot for an insert, moved back-reference for a delete.
//   One command at a time: in_ready is high only while the sequencer waits.
//   A command steps through dependent single-port reads and writes of the
//   group, edge key, back-reference and link memories before its result;
//   errors skip to the result early. After reset the block runs a clearing
//   pass over every entry of the group and edge key memories before it
//   first raises in_ready.
//   The result is held in an output register; while the receiver stalls,
//   no new command is taken.
// ----------------------------------------------------------------------------
module edge_block_list_manager #(
  parameter int GROUP_WIDTH = 1,
  parameter int BLOCK_SLOTS = 8,
  parameter int NUM_GROUPS  = 4096,
  parameter int NUM_BLOCKS  = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [19:0] vertex_id,
  input  logic [19:0] edge_dest,
  input  logic [15:0] edge_weight,
  input  logic [19:0] home_vertex,
  input  logic [15:0] home_block,
  input  logic [7:0]  home_offset,
  input  logic        main_copy_gen,
  input  logic [12:0] slot_block,
  input  logic [2:0]  slot_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [12:0] placed_block,
  output logic [2:0]  placed_index,
  output logic        moved,
  output logic [19:0] moved_home_vertex,
  output logic [15:0] moved_home_block,
  output logic [7:0]  moved_home_offset,
  output logic        moved_main_copy_gen
);
  import eblm_pkg::*;

  localparam int GW    = $clog2(NUM_GROUPS);
  localparam int BW    = $clog2(NUM_BLOCKS + 1);   // holds NUM_BLOCKS = none
  localparam int BAW   = $clog2(NUM_BLOCKS);
  localparam int FW    = $clog2(BLOCK_SLOTS + 1);
  localparam int SLOTS = NUM_BLOCKS * BLOCK_SLOTS;
  localparam int EW    = $clog2(SLOTS);
  localparam int CLRN  = (NUM_GROUPS > SLOTS) ? NUM_GROUPS : SLOTS;
  localparam int CW    = $clog2(CLRN + 1);
  localparam int GRPW  = 1 + BW + FW + 20;
  localparam logic [BW-1:0] NO_BLK = BW'(NUM_BLOCKS);
  localparam logic [FW-1:0] FULL   = FW'(BLOCK_SLOTS);

  typedef struct packed {
    logic          valid;
    logic [BW-1:0] tail;
    logic [FW-1:0] fill;
    logic [19:0]   count;
  } grp_t;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_RD1   = 12'b000000000100,
    S_EX1   = 12'b000000001000,
    S_INS   = 12'b000000010000,
    S_DRD   = 12'b000000100000,
    S_DEX   = 12'b000001000000,
    S_DSRC  = 12'b000010000000,
    S_DMOV  = 12'b000100000000,
    S_DCLR  = 12'b001000000000,
    S_OUT   = 12'b010000000000,
    S_RDK   = 12'b100000000000
  } state_t;

  state_t state;
  logic [CW-1:0] clr_cnt;

  // captured command
  logic [2:0]  c_mode;
  logic [19:0] c_dest;
  logic [15:0] c_wt;
  edge_ref_t   c_ref;
  logic [GW-1:0] c_grp;
  logic        c_grp_bad;
  logic [EW-1:0] c_slot;
  logic        c_slot_bad;
  logic [BW-1:0] alloc_ptr;
  grp_t        g;
  logic [EW-1:0] src;
  edge_key_t   src_key;

  // memory ports
  logic          g_we, k_we, r_we, p_we, n_we;
  logic [GW-1:0] g_addr;
  logic [EW-1:0] k_addr, r_addr;
  logic [BAW-1:0] p_addr, n_addr;
  logic [GRPW-1:0] g_wd, g_rd;
  logic [KEY_W-1:0] k_wd, k_rd;
  logic [REF_W-1:0] r_wd, r_rd;
  logic [BW-1:0] p_wd, p_rd, n_wd, n_rd;

  eblm_ram #(.WIDTH(GRPW), .DEPTH(NUM_GROUPS)) u_grp (
    .clk, .we(g_we), .addr(g_addr), .wdata(g_wd), .rdata(g_rd));
  eblm_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key (
    .clk, .we(k_we), .addr(k_addr), .wdata(k_wd), .rdata(k_rd));
  eblm_ram #(.WIDTH(REF_W), .DEPTH(SLOTS)) u_ref (
    .clk, .we(r_we), .addr(r_addr), .wdata(r_wd), .rdata(r_rd));
  eblm_ram #(.WIDTH(BW), .DEPTH(NUM_BLOCKS)) u_prev (
    .clk, .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd));
  eblm_ram #(.WIDTH(BW), .DEPTH(NUM_BLOCKS)) u_next (
    .clk, .we(n_we), .addr(n_addr), .wdata(n_wd), .rdata(n_rd));

  grp_t      g_rd_s;
  edge_key_t k_rd_s;
  assign g_rd_s = grp_t'(g_rd);
  assign k_rd_s = edge_key_t'(k_rd);

  // decode of the incoming command
  logic [19:0] grp_full;
  assign grp_full = vertex_id / 20'(GROUP_WIDTH);

  assign in_ready = (state == S_IDLE);

  // group record after allocation decision
  logic need_blk;
  grp_t g_ins;
  logic [EW-1:0] ins_at;
  assign need_blk = !g.valid || g.tail >= NO_BLK || g.fill >= FULL;
  always_comb begin
    g_ins = g;
    if (need_blk) begin
      if (!g.valid) begin
        g_ins.count = '0;
      end
      g_ins.valid = 1'b1;
      g_ins.tail  = alloc_ptr;
      g_ins.fill  = '0;
    end
    ins_at = EW'(g_ins.tail[BAW-1:0]) * EW'(BLOCK_SLOTS) + EW'(g_ins.fill);
  end

  // memory port control
  always_comb begin
    g_we = 1'b0; k_we = 1'b0; r_we = 1'b0; p_we = 1'b0; n_we = 1'b0;
    g_addr = c_grp; g_wd = g;
    k_addr = c_slot; k_wd = k_rd;
    r_addr = c_slot; r_wd = c_ref;
    p_addr = g.tail[BAW-1:0]; p_wd = NO_BLK;
    n_addr = g.tail[BAW-1:0]; n_wd = NO_BLK;
    unique case (state)
      S_CLEAR: begin
        g_we = (clr_cnt < CW'(NUM_GROUPS));
        g_addr = clr_cnt[GW-1:0];
        g_wd = '0;
        k_we = (clr_cnt < CW'(SLOTS));
        k_addr = clr_cnt[EW-1:0];
        k_wd = '0;
      end
      S_INS: begin
        g_we = 1'b1;
        g_wd = g_ins;
        g_wd[FW+19:20] = g_ins.fill + FW'(1);
        if (g_ins.count != 20'hFFFFF) begin
          g_wd[19:0] = g_ins.count + 20'd1;
        end
        k_we = 1'b1; k_addr = ins_at;
        k_wd = {c_dest, c_wt, 1'b1};
        r_we = 1'b1; r_addr = ins_at; r_wd = c_ref;
        if (need_blk) begin
          p_we = 1'b1; p_addr = alloc_ptr[BAW-1:0];
          p_wd = (g.valid && g.tail < NO_BLK) ? g.tail : NO_BLK;
          n_we = 1'b1; n_addr = alloc_ptr[BAW-1:0]; n_wd = NO_BLK;
        end
      end
      S_EX1: begin
        if (c_mode == MODE_INCR) begin
          k_we = 1'b1;
          k_wd = k_rd_s;
          if (k_rd_s.weight != 16'hFFFF) begin
            k_wd[16:1] = k_rd_s.weight + 16'd1;
          end
        end else if (c_mode == MODE_INVAL) begin
          k_we = 1'b1;
          k_wd = {k_rd_s.dest, k_rd_s.weight, 1'b0};
        end else if (c_mode == MODE_SETREF) begin
          // home fields from the command, stored generation kept
          r_we = 1'b1;
          r_wd = {c_ref.hvtx, c_ref.hblock, c_ref.hoff, r_rd[0]};
        end
      end
      S_DRD: begin
        // hole key read at c_slot is settled: invalidate the hole
        k_we = 1'b1;
        k_wd = {k_rd_s.dest, k_rd_s.weight, 1'b0};
      end
      S_DCLR: begin
        // write back the group record
        g_we = 1'b1;
      end
      S_DEX: begin
        // step back: unlink the previous block
        n_addr = p_rd[BAW-1:0];
        n_we = (g.tail < NO_BLK) && (g.fill == '0) && (p_rd < NO_BLK);
      end
      S_DSRC: begin
        k_addr = src;
        r_addr = src;
      end
      S_DMOV: begin
        k_we = 1'b1; k_wd = k_rd;
        r_we = 1'b1; r_wd = r_rd;
      end
      S_RDK: begin
        k_we = 1'b1; k_addr = src;
        k_wd = {src_key.dest, src_key.weight, 1'b0};
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      alloc_ptr <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CW'(1);
          if (clr_cnt == CW'(CLRN - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            c_mode <= mode; c_dest <= edge_dest; c_wt <= edge_weight;
            c_ref <= {home_vertex, home_block, home_offset, main_copy_gen};
            c_grp <= grp_full[GW-1:0];
            c_grp_bad <= grp_full >= 20'(NUM_GROUPS);
            c_slot <= EW'(slot_block[BAW-1:0]) * EW'(BLOCK_SLOTS) + EW'(slot_index);
            c_slot_bad <= (14'(slot_block) >= 14'(NUM_BLOCKS)) ||
                          (7'(slot_index) >= 7'(BLOCK_SLOTS));
            status <= ST_DONE; placed_block <= '0; placed_index <= '0;
            moved <= 1'b0; moved_home_vertex <= '0; moved_home_block <= '0;
            moved_home_offset <= '0; moved_main_copy_gen <= 1'b0;
            state <= S_RD1;
          end
        end
        S_RD1: begin
          // memory address settles; reads arrive next cycle
          if (c_mode > 3'(MODE_SETREF) ||
              (c_mode != MODE_INSERT && c_slot_bad) ||
              ((c_mode == MODE_INSERT || c_mode == MODE_DELETE) && c_grp_bad)) begin
            status <= ST_BADGRP;
            state <= S_OUT;
            out_valid <= 1'b1;
          end else begin
            state <= S_EX1;
          end
        end
        S_EX1: begin
          g <= g_rd_s;
          unique case (c_mode)
            MODE_INSERT: state <= S_INS;
            MODE_DELETE: state <= g_rd_s.valid ? S_DRD : S_OUT;
            default: state <= S_OUT;
          endcase
          if (c_mode == MODE_INSERT) begin
            if ((!g_rd_s.valid || g_rd_s.tail >= NO_BLK || g_rd_s.fill >= FULL) &&
                alloc_ptr >= NO_BLK) begin
              status <= ST_NOALLOC;
              state <= S_OUT;
            end
          end else if (c_mode == MODE_DELETE && !g_rd_s.valid) begin
            status <= ST_BADGRP;
          end
          if (!(c_mode == MODE_INSERT)) begin
            out_valid <= !(c_mode == MODE_DELETE && g_rd_s.valid);
          end else if ((!g_rd_s.valid || g_rd_s.tail >= NO_BLK ||
                        g_rd_s.fill >= FULL) && alloc_ptr >= NO_BLK) begin
            out_valid <= 1'b1;
          end
        end
        S_INS: begin
          if (need_blk) begin
            alloc_ptr <= alloc_ptr + BW'(1);
          end
          placed_block <= 13'(g_ins.tail);
          placed_index <= 3'(g_ins.fill);
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_DRD: begin
          // prev link of the tail is being read
          state <= S_DEX;
          src <= EW'(g.tail[BAW-1:0]) * EW'(BLOCK_SLOTS) + EW'(g.fill - FW'(1));
        end
        S_DEX: begin
          if (g.tail >= NO_BLK) begin
            state <= S_DCLR;
            src <= c_slot;
          end else begin
            if (g.count != '0) begin
              g.count <= g.count - 20'd1;
            end
            if (g.fill != '0) begin
              g.fill <= g.fill - FW'(1);
              state <= S_DSRC;
            end else if (p_rd >= NO_BLK) begin
              g.tail <= NO_BLK; g.fill <= '0;
              state <= S_DCLR;
              src <= c_slot;
            end else begin
              g.tail <= p_rd;
              g.fill <= FW'(BLOCK_SLOTS - 1);
              src <= EW'(p_rd[BAW-1:0]) * EW'(BLOCK_SLOTS) + EW'(BLOCK_SLOTS - 1);
              state <= S_DSRC;
            end
          end
        end
        S_DSRC: begin
          // source key and ref are being read
          if (src == c_slot) begin
            state <= S_DCLR;
          end else begin
            state <= S_DMOV;
          end
        end
        S_DMOV: begin
          src_key <= k_rd_s;
          moved <= 1'b1;
          moved_home_vertex <= r_rd[44:25];
          moved_home_block <= r_rd[24:9];
          moved_home_offset <= r_rd[8:1];
          moved_main_copy_gen <= r_rd[0];
          state <= S_RDK;
        end
        S_RDK: begin
          // source slot's valid bit is cleared this cycle
          state <= S_DCLR;
        end
        S_DCLR: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end else if (!out_valid) begin
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid) else $error("result repeated");
  a_alloc_mono: assert property (@(posedge clk) disable iff (rst)
    alloc_ptr >= $past(alloc_ptr)) else $error("allocator moved back");
`endif

endmodule

@@ hdl/eblm_ram.sv @@
// ----------------------------------------------------------------------------
// eblm_ram: generic single-port RAM
// One read per cycle, plus a write when we is set; read data is registered.
// ----------------------------------------------------------------------------
module eblm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
